FILE: hdl/crcpr_pkg.sv
package crcpr_pkg;

    localparam logic [7:0]  START_BYTE     = 8'h42;
    localparam logic [7:0]  BROADCAST_ADDR = 8'hff;
    localparam logic [15:0] CRC_POLY       = 16'h1021;
    localparam logic [15:0] CRC_MSB        = 16'h8000;

    // Result kinds.
    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Verdict codes.
    localparam logic [1:0] VERDICT_OK       = 2'd0;
    localparam logic [1:0] VERDICT_OTHER    = 2'd1;
    localparam logic [1:0] VERDICT_CRC_FAIL = 2'd2;

    // Parser phases, one-hot.
    typedef enum logic [7:0] {
        PH_IDLE   = 8'b0000_0001,
        PH_ADDR   = 8'b0000_0010,
        PH_LEN_LO = 8'b0000_0100,
        PH_LEN_HI = 8'b0000_1000,
        PH_TYPE   = 8'b0001_0000,
        PH_DATA   = 8'b0010_0000,
        PH_CRC_LO = 8'b0100_0000,
        PH_CRC_HI = 8'b1000_0000
    } phase_t;

    // One result beat produced by the parser.
    typedef struct packed {
        logic        valid;
        logic        result_kind;
        logic [7:0]  payload_byte;
        logic [15:0] byte_index;
        logic [7:0]  dest_address;
        logic [7:0]  packet_type;
        logic [15:0] packet_length;
        logic [1:0]  verdict;
    } result_t;

    // CRC-16 update with one byte, MSB first, polynomial 0x1021.
    function automatic logic [15:0] crc_add_byte(input logic [15:0] crc,
                                                 input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_MSB) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: hdl/crcpr_parser.sv
module crcpr_parser (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step,
    input  logic [7:0]             rx_byte,
    input  logic [7:0]             own_address,
    output crcpr_pkg::result_t     res
);

    crcpr_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  addr_reg, addr_next;
    logic [15:0] len_reg, len_next;
    logic [7:0]  type_reg, type_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crc_lo_reg, crc_lo_next;

    logic [15:0] crc_upd;
    logic [15:0] count_inc;
    logic [15:0] rx_crc;

    assign crc_upd   = crcpr_pkg::crc_add_byte(crc_reg, rx_byte);
    assign count_inc = count_reg + 16'd1;
    assign rx_crc    = {rx_byte, crc_lo_reg};

    // Next state and result for the byte in the input register.
    always_comb begin
        phase_next  = phase_reg;
        addr_next   = addr_reg;
        len_next    = len_reg;
        type_next   = type_reg;
        count_next  = count_reg;
        crc_next    = crc_reg;
        crc_lo_next = crc_lo_reg;

        res               = '0;
        res.dest_address  = addr_reg;
        res.packet_type   = type_reg;
        res.packet_length = len_reg;

        unique case (phase_reg)
            crcpr_pkg::PH_IDLE: begin
                if (rx_byte == crcpr_pkg::START_BYTE) begin
                    crc_next   = crcpr_pkg::crc_add_byte(16'h0000, rx_byte);
                    phase_next = crcpr_pkg::PH_ADDR;
                end
            end
            crcpr_pkg::PH_ADDR: begin
                addr_next  = rx_byte;
                crc_next   = crc_upd;
                phase_next = crcpr_pkg::PH_LEN_LO;
            end
            crcpr_pkg::PH_LEN_LO: begin
                len_next   = {8'h00, rx_byte};
                crc_next   = crc_upd;
                phase_next = crcpr_pkg::PH_LEN_HI;
            end
            crcpr_pkg::PH_LEN_HI: begin
                len_next   = {rx_byte, len_reg[7:0]};
                crc_next   = crc_upd;
                phase_next = crcpr_pkg::PH_TYPE;
            end
            crcpr_pkg::PH_TYPE: begin
                type_next  = rx_byte;
                crc_next   = crc_upd;
                count_next = 16'd0;
                phase_next = (len_reg != 16'd0) ? crcpr_pkg::PH_DATA
                                                : crcpr_pkg::PH_CRC_LO;
            end
            crcpr_pkg::PH_DATA: begin
                crc_next   = crc_upd;
                count_next = count_inc;
                if (count_inc >= len_reg) begin
                    phase_next = crcpr_pkg::PH_CRC_LO;
                end
                res.valid        = 1'b1;
                res.result_kind  = crcpr_pkg::KIND_DATA;
                res.payload_byte = rx_byte;
                res.byte_index   = count_reg;
            end
            crcpr_pkg::PH_CRC_LO: begin
                crc_lo_next = rx_byte;
                phase_next  = crcpr_pkg::PH_CRC_HI;
            end
            crcpr_pkg::PH_CRC_HI: begin
                phase_next      = crcpr_pkg::PH_IDLE;
                res.valid       = 1'b1;
                res.result_kind = crcpr_pkg::KIND_VERDICT;
                // The address check takes precedence over the CRC check.
                if (addr_reg != own_address && addr_reg != crcpr_pkg::BROADCAST_ADDR) begin
                    res.verdict = crcpr_pkg::VERDICT_OTHER;
                end else if (rx_crc != crc_reg) begin
                    res.verdict = crcpr_pkg::VERDICT_CRC_FAIL;
                end else begin
                    res.verdict = crcpr_pkg::VERDICT_OK;
                end
            end
            default: begin
                phase_next = crcpr_pkg::PH_IDLE;
            end
        endcase

        // Only a consumed byte produces a result.
        res.valid = res.valid & step;
    end

    // Parser state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= crcpr_pkg::PH_IDLE;
            addr_reg   <= 8'h00;
            len_reg    <= 16'h0000;
            type_reg   <= 8'h00;
            count_reg  <= 16'h0000;
            crc_reg    <= 16'h0000;
            crc_lo_reg <= 8'h00;
        end else if (step) begin
            phase_reg  <= phase_next;
            addr_reg   <= addr_next;
            len_reg    <= len_next;
            type_reg   <= type_next;
            count_reg  <= count_next;
            crc_reg    <= crc_next;
            crc_lo_reg <= crc_lo_next;
        end
    end

    // A payload byte always yields a data result.
    a_data_result: assert property (@(posedge aclk) disable iff (!aresetn)
        step && phase_reg == crcpr_pkg::PH_DATA |->
            res.valid && res.result_kind == crcpr_pkg::KIND_DATA)
        else $error("payload byte without data result");

    // After the second CRC byte the parser hunts again.
    a_back_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        step && phase_reg == crcpr_pkg::PH_CRC_HI |=> phase_reg == crcpr_pkg::PH_IDLE)
        else $error("parser did not return to hunting after verdict");

    // A byte other than the start byte is dropped while hunting.
    a_hunt_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        step && phase_reg == crcpr_pkg::PH_IDLE && rx_byte != crcpr_pkg::START_BYTE
            |-> !res.valid ##1 phase_reg == crcpr_pkg::PH_IDLE)
        else $error("non-start byte left hunting state or produced a result");

    // The payload counter restarts at the type byte.
    a_count_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        step && phase_reg == crcpr_pkg::PH_TYPE |=> count_reg == 16'd0)
        else $error("payload counter not cleared after type byte");

endmodule

FILE: hdl/crcpr_out_reg.sv
module crcpr_out_reg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  crcpr_pkg::result_t   res,
    output logic                 can_take,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_result_kind,
    output logic [7:0]           m_payload_byte,
    output logic [15:0]          m_byte_index,
    output logic [7:0]           m_dest_address,
    output logic [7:0]           m_packet_type,
    output logic [15:0]          m_packet_length,
    output logic [1:0]           m_verdict
);

    logic               valid_reg, valid_next;
    crcpr_pkg::result_t data_reg;

    // The slot is free when empty or when its beat leaves this cycle.
    assign can_take   = !valid_reg || m_ready;
    assign valid_next = res.valid || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Result payload, loaded only with a new beat.
    always_ff @(posedge aclk) begin
        if (res.valid) begin
            data_reg <= res;
        end
    end

    assign m_valid         = valid_reg;
    assign m_result_kind   = data_reg.result_kind;
    assign m_payload_byte  = data_reg.payload_byte;
    assign m_byte_index    = data_reg.byte_index;
    assign m_dest_address  = data_reg.dest_address;
    assign m_packet_type   = data_reg.packet_type;
    assign m_packet_length = data_reg.packet_length;
    assign m_verdict       = data_reg.verdict;

endmodule

FILE: hdl/crc_checked_packet_receiver.sv
// A byte accepted into the input register passes the byte-wide CRC step and
// parser decode into the result register, which drives the m_ ports.
// Throughput: one byte per cycle while the result slot can take it; m_ready low
// with a full result register stalls the input register.
// Reset (aresetn low at a clock edge) empties both registers, returns the
// parser to hunting for the start byte and clears own_address to zero.
module crc_checked_packet_receiver (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_own_address,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [7:0]   s_rx_byte,
    output logic         m_valid,
    input  logic         m_ready,
    output logic         m_result_kind,
    output logic [7:0]   m_payload_byte,
    output logic [15:0]  m_byte_index,
    output logic [7:0]   m_dest_address,
    output logic [7:0]   m_packet_type,
    output logic [15:0]  m_packet_length,
    output logic [1:0]   m_verdict
);

    logic [7:0]         own_address_reg;
    logic               in_valid_reg, in_valid_next;
    logic [7:0]         in_byte_reg;
    logic               can_take;
    logic               step;
    crcpr_pkg::result_t res;

    // Configuration register, always writable.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_address_reg <= 8'h00;
        end else if (cfg_valid) begin
            own_address_reg <= cfg_own_address;
        end
    end

    // Input register: the byte is consumed once the result slot can take it.
    assign step          = in_valid_reg && can_take;
    assign s_ready       = !in_valid_reg || can_take;
    assign in_valid_next = (s_valid && s_ready) || (in_valid_reg && !step);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    crcpr_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .rx_byte     (in_byte_reg),
        .own_address (own_address_reg),
        .res         (res)
    );

    crcpr_out_reg u_out_reg (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .res             (res),
        .can_take        (can_take),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_payload_byte  (m_payload_byte),
        .m_byte_index    (m_byte_index),
        .m_dest_address  (m_dest_address),
        .m_packet_type   (m_packet_type),
        .m_packet_length (m_packet_length),
        .m_verdict       (m_verdict)
    );

endmodule
